// File: rtl/tss_pkg.sv
// Shared types and constants for the triangle scanline span unit.
// No dependencies; every other file imports this package.
package tss_pkg;

  // Default widths, used as the defaults of the top level parameters.
  localparam int unsigned CoordBitsDef = 12;
  localparam int unsigned FracBitsDef  = 16;

  // Depth of the queue between front and back.
  localparam int unsigned QueueDepth = 2;

  // Configuration register map.
  localparam int unsigned CfgIdxBits = 3;
  localparam logic [CfgIdxBits-1:0] RegAX = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegAY = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegBX = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegBY = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegCX = 3'd4;
  localparam logic [CfgIdxBits-1:0] RegCY = 3'd5;

  // Edge slots in the slope table.
  typedef enum logic [1:0] {
    EDGE_UB = 2'd0,  // top to bottom
    EDGE_UM = 2'd1,  // top to middle
    EDGE_MB = 2'd2   // middle to bottom
  } tss_edge_e;

  // Setup sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_LOAD,
    ST_DIV
  } tss_state_e;

  // Flow status handed from the queue to front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } tss_qstat_t;

endpackage

// File: rtl/tss_setup.sv
// Vertex registers, sort and slope divider of the span unit.
// Depends on tss_pkg. Reruns after every configuration write.
module tss_setup
  import tss_pkg::*;
#(
  parameter int unsigned COORD_BITS      = CoordBitsDef,
  parameter int unsigned SLOPE_FRAC_BITS = FracBitsDef
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         wr_i,
  input  logic [CfgIdxBits-1:0]                        wr_idx_i,
  input  logic [COORD_BITS-1:0]                        wr_data_i,
  output logic                                         busy_o,
  output logic [COORD_BITS-1:0]                        xu_o,
  output logic [COORD_BITS-1:0]                        yu_o,
  output logic [COORD_BITS-1:0]                        ym_o,
  output logic [COORD_BITS-1:0]                        xb_o,
  output logic [COORD_BITS-1:0]                        yb_o,
  output logic signed [COORD_BITS+SLOPE_FRAC_BITS:0]   s_ub_o,
  output logic signed [COORD_BITS+SLOPE_FRAC_BITS:0]   s_um_o,
  output logic signed [COORD_BITS+SLOPE_FRAC_BITS:0]   s_mb_o
);

  localparam int unsigned NB = COORD_BITS + SLOPE_FRAC_BITS;
  localparam int unsigned SW = NB + 1;
  localparam int unsigned CW = $clog2(NB);

  logic [COORD_BITS-1:0] vx_q [3];
  logic [COORD_BITS-1:0] vy_q [3];
  logic [COORD_BITS-1:0] xu_q, yu_q, xm_q, ym_q, xb_q, yb_q;
  logic signed [SW-1:0]  slope_q [3];

  tss_state_e state_q, state_d;
  tss_edge_e  edge_q;
  logic [CW-1:0]          cnt_q;
  logic [NB-1:0]          num_q;
  logic [COORD_BITS-1:0]  den_q, rem_q;
  logic                   neg_q, zero_q;

  // sort network: three compare-and-swap steps, swap on strictly smaller y
  logic [1:0] t0, m0, t1, b1, m2, b2;
  always_comb begin
    t0 = 2'd0; m0 = 2'd1;
    if (vy_q[1] < vy_q[0]) begin
      t0 = 2'd1; m0 = 2'd0;
    end
    t1 = t0; b1 = 2'd2;
    if (vy_q[2] < vy_q[t0]) begin
      t1 = 2'd2; b1 = t0;
    end
    m2 = m0; b2 = b1;
    if (vy_q[b1] < vy_q[m0]) begin
      m2 = b1; b2 = m0;
    end
  end

  // divider operands for the current edge
  logic [COORD_BITS-1:0] ex1, ey1, ex2, ey2;
  logic signed [COORD_BITS:0] dx;
  logic [COORD_BITS-1:0] dx_mag;
  always_comb begin
    case (edge_q)
      EDGE_UB: begin ex1 = xu_q; ey1 = yu_q; ex2 = xb_q; ey2 = yb_q; end
      EDGE_UM: begin ex1 = xu_q; ey1 = yu_q; ex2 = xm_q; ey2 = ym_q; end
      EDGE_MB: begin ex1 = xm_q; ey1 = ym_q; ex2 = xb_q; ey2 = yb_q; end
      default: begin ex1 = xu_q; ey1 = yu_q; ex2 = xb_q; ey2 = yb_q; end
    endcase
    dx     = $signed({1'b0, ex2}) - $signed({1'b0, ex1});
    dx_mag = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
  end

  // one restoring step per cycle
  logic [COORD_BITS:0] trial;
  logic                qbit;
  always_comb begin
    trial = {rem_q, num_q[NB-1]};
    qbit  = (trial >= {1'b0, den_q});
  end

  logic last_step;
  assign last_step = (cnt_q == CW'(NB - 1));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: state_d = ST_IDLE;
      ST_SORT: state_d = ST_LOAD;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV: begin
        if (last_step) begin
          state_d = (edge_q == EDGE_MB) ? ST_IDLE : ST_LOAD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (wr_i) begin
      state_d = ST_SORT;
    end
  end

  // outputs
  always_comb begin
    busy_o = (state_q != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      edge_q  <= EDGE_UB;
      cnt_q   <= '0;
      for (int i = 0; i < 3; i++) begin
        vx_q[i]    <= '0;
        vy_q[i]    <= '0;
        slope_q[i] <= '0;
      end
      xu_q <= '0; yu_q <= '0; xm_q <= '0;
      ym_q <= '0; xb_q <= '0; yb_q <= '0;
    end else begin
      state_q <= state_d;
      if (wr_i) begin
        case (wr_idx_i)
          RegAX:   vx_q[0] <= wr_data_i;
          RegAY:   vy_q[0] <= wr_data_i;
          RegBX:   vx_q[1] <= wr_data_i;
          RegBY:   vy_q[1] <= wr_data_i;
          RegCX:   vx_q[2] <= wr_data_i;
          RegCY:   vy_q[2] <= wr_data_i;
          default: ;
        endcase
      end else begin
        case (state_q)
          ST_SORT: begin
            xu_q <= vx_q[t1]; yu_q <= vy_q[t1];
            xm_q <= vx_q[m2]; ym_q <= vy_q[m2];
            xb_q <= vx_q[b2]; yb_q <= vy_q[b2];
            edge_q <= EDGE_UB;
          end
          ST_LOAD: begin
            cnt_q <= '0;
          end
          ST_DIV: begin
            cnt_q <= cnt_q + CW'(1);
            if (last_step) begin
              slope_q[edge_q] <= zero_q ? '0 :
                                 neg_q  ? -$signed({1'b0, num_q[NB-2:0], qbit})
                                        :  $signed({1'b0, num_q[NB-2:0], qbit});
              case (edge_q)
                EDGE_UB: edge_q <= EDGE_UM;
                EDGE_UM: edge_q <= EDGE_MB;
                default: edge_q <= EDGE_UB;
              endcase
            end
          end
          default: ;
        endcase
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      num_q  <= {dx_mag, {SLOPE_FRAC_BITS{1'b0}}};
      den_q  <= ey2 - ey1;
      rem_q  <= '0;
      neg_q  <= dx[COORD_BITS];
      zero_q <= (ey2 == ey1);
    end else if (state_q == ST_DIV) begin
      num_q <= {num_q[NB-2:0], qbit};
      rem_q <= qbit ? COORD_BITS'(trial - {1'b0, den_q}) : trial[COORD_BITS-1:0];
    end
  end

  assign xu_o   = xu_q;
  assign yu_o   = yu_q;
  assign ym_o   = ym_q;
  assign xb_o   = xb_q;
  assign yb_o   = yb_q;
  assign s_ub_o = slope_q[EDGE_UB];
  assign s_um_o = slope_q[EDGE_UM];
  assign s_mb_o = slope_q[EDGE_MB];

endmodule

// File: rtl/tss_front.sv
// Row intake of the span unit: classifies a row against the sorted vertices.
// Depends on tss_pkg.
module tss_front
  import tss_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic [COORD_BITS-1:0]   row_i,
  input  logic                    busy_i,
  input  tss_qstat_t              qstat_i,
  input  logic [COORD_BITS-1:0]   yu_i,
  input  logic [COORD_BITS-1:0]   ym_i,
  input  logic [COORD_BITS-1:0]   yb_i,
  output logic                    push_o,
  output logic [COORD_BITS+2:0]   entry_o
);

  logic outside, upper;
  logic signed [COORD_BITS:0] delta;

  always_comb begin
    outside = (row_i < yu_i) || (row_i > yb_i);
    upper   = (row_i < ym_i);
    // upper half measured from the top vertex, lower half from the bottom
    delta   = upper ? $signed({1'b0, row_i}) - $signed({1'b0, yu_i})
                    : $signed({1'b0, row_i}) - $signed({1'b0, yb_i});
  end

  assign ready_o = !busy_i && !qstat_i.full;
  assign push_o  = valid_i && ready_o;
  assign entry_o = {outside, upper, delta};

endmodule

// File: rtl/tss_queue.sv
// Small FIFO between front and back of the span unit.
// Depends on tss_pkg.
module tss_queue
  import tss_pkg::*;
#(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output tss_qstat_t       stat_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wp_q, rp_q;
  logic [NW-1:0]    cnt_q;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= inc(wp_q);
      if (pop_i)  rp_q <= inc(rp_q);
      if (push_i && !pop_i) cnt_q <= cnt_q + NW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - NW'(1);
    end
  end

  assign data_o       = mem_q[rp_q];
  assign stat_o.full  = (cnt_q == NW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);

endmodule

// File: rtl/tss_back.sv
// Span evaluation of the span unit: slope multiply, edge x, floor/ceil, clamp.
// Depends on tss_pkg; takes classified rows from tss_queue.
module tss_back
  import tss_pkg::*;
#(
  parameter int unsigned COORD_BITS      = CoordBitsDef,
  parameter int unsigned SLOPE_FRAC_BITS = FracBitsDef
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  tss_qstat_t                                 qstat_i,
  input  logic [COORD_BITS+2:0]                      entry_i,
  output logic                                       pop_o,
  input  logic [COORD_BITS-1:0]                      xu_i,
  input  logic [COORD_BITS-1:0]                      xb_i,
  input  logic signed [COORD_BITS+SLOPE_FRAC_BITS:0] s_ub_i,
  input  logic signed [COORD_BITS+SLOPE_FRAC_BITS:0] s_um_i,
  input  logic signed [COORD_BITS+SLOPE_FRAC_BITS:0] s_mb_i,
  output logic                                       valid_o,
  input  logic                                       ready_i,
  output logic                                       covered_o,
  output logic [COORD_BITS-1:0]                      start_o,
  output logic [COORD_BITS:0]                        end_o
);

  localparam int unsigned SW = COORD_BITS + SLOPE_FRAC_BITS + 1;
  localparam int unsigned PW = SW + COORD_BITS + 1;
  localparam int unsigned EW = PW + 1;
  localparam logic signed [EW-1:0] Round = EW'((64'd1 << SLOPE_FRAC_BITS) - 64'd1);
  localparam logic [EW-1:0] MaxStart = EW'((64'd1 << COORD_BITS) - 64'd1);
  localparam logic [EW-1:0] MaxEnd   = EW'(64'd1 << COORD_BITS);

  logic outside, upper;
  logic signed [COORD_BITS:0] delta;
  assign {outside, upper, delta} = entry_i;

  // stage 1: two products
  logic                  s1_valid_q, s1_out_q;
  logic [COORD_BITS-1:0] s1_x_q;
  logic signed [PW-1:0]  s1_p1_q, s1_p2_q;
  logic                  adv_out, adv_s1;
  logic signed [SW-1:0]  sl1;

  assign adv_out = !valid_o || ready_i;
  assign adv_s1  = !s1_valid_q || adv_out;
  assign pop_o   = !qstat_i.empty && adv_s1;
  assign sl1     = upper ? s_um_i : s_mb_i;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_out_q <= outside;
      s1_x_q   <= upper ? xu_i : xb_i;
      s1_p1_q  <= PW'(sl1) * PW'(delta);
      s1_p2_q  <= PW'(s_ub_i) * PW'(delta);
    end
  end

  // stage 2: edge x, ordering, floor/ceil and clamp
  logic signed [EW-1:0] bx, e1, e2, lo, hi, lsh, hsh;
  logic [COORD_BITS-1:0] st;
  logic [COORD_BITS:0]   en;
  logic                  cov;

  always_comb begin
    bx  = EW'($signed({1'b0, s1_x_q})) <<< SLOPE_FRAC_BITS;
    e1  = bx + EW'(s1_p1_q);
    e2  = bx + EW'(s1_p2_q);
    lo  = (e1 < e2) ? e1 : e2;
    hi  = (e1 < e2) ? e2 : e1;
    lsh = lo >>> SLOPE_FRAC_BITS;
    hsh = (hi + Round) >>> SLOPE_FRAC_BITS;
    if (lo < 0)                   st = '0;
    else if ($unsigned(lsh) > MaxStart) st = MaxStart[COORD_BITS-1:0];
    else                          st = lsh[COORD_BITS-1:0];
    if (hi <= 0)                  en = '0;
    else if ($unsigned(hsh) > MaxEnd) en = MaxEnd[COORD_BITS:0];
    else                          en = hsh[COORD_BITS:0];
    cov = !s1_out_q && (en > {1'b0, st});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      valid_o    <= 1'b0;
    end else begin
      if (adv_s1) s1_valid_q <= pop_o;
      if (adv_out) valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && s1_valid_q) begin
      covered_o <= cov;
      start_o   <= cov ? st : '0;
      end_o     <= cov ? en : '0;
    end
  end

endmodule

// File: rtl/triangle_scanline_span_unit.sv
// Top level of the triangle scanline span unit.
// Depends on tss_pkg, tss_setup, tss_front, tss_queue and tss_back.
//
//  channel  | direction | transaction moves
//  ---------+-----------+--------------------------------------------------
//  cfg      | in        | cfg_index_i selects a vertex coordinate, cfg_data_i
//  s_axis   | in        | one raster row
//  m_axis   | out       | covered flag, span start, exclusive span end
//
// One row per clock once setup is done and the output is not stalled; a taken
// row passes the queue write, multiply stage and span stage to the output reg.
// A configuration write restarts setup: a sort step, then three slope
// divisions on a shared restoring divider, each a load step and then the
// restoring steps; s_axis_tready stays low through it.
// Reset leaves all vertices at zero with zero slopes, ready at once.
// Output stalls back up through the two-entry queue into s_axis_tready.
module triangle_scanline_span_unit
  import tss_pkg::*;
#(
  parameter int unsigned COORD_BITS      = CoordBitsDef,
  parameter int unsigned SLOPE_FRAC_BITS = FracBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration writes
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgIdxBits-1:0]   cfg_index_i,
  input  logic [COORD_BITS-1:0]   cfg_data_i,
  // rows in
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // [COORD_BITS-1:0] row, rest zero
  input  logic [((COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // spans out
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // [0] covered, [COORD_BITS:1] span_start, [2*COORD_BITS+1:COORD_BITS+1] span_end
  output logic [((2*COORD_BITS+2+7)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned SW   = COORD_BITS + SLOPE_FRAC_BITS + 1;
  localparam int unsigned QW   = COORD_BITS + 3;
  localparam int unsigned OW   = ((2*COORD_BITS + 2 + 7) / 8) * 8;
  localparam int unsigned OPAD = OW - (2*COORD_BITS + 2);

  logic                    busy, push, pop;
  logic [COORD_BITS-1:0]   xu, yu, ym, xb, yb;
  logic signed [SW-1:0]    s_ub, s_um, s_mb;
  logic [QW-1:0]           q_in, q_out;
  tss_qstat_t              qstat;
  logic                    covered;
  logic [COORD_BITS-1:0]   span_start;
  logic [COORD_BITS:0]     span_end;

  // registers are always writable; each write restarts setup, so the source must
  // write only while no rows are in flight; the block itself does not enforce it
  assign cfg_ready_o = 1'b1;

  tss_setup #(
    .COORD_BITS      (COORD_BITS),
    .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
  ) u_setup (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (cfg_valid_i && cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .busy_o    (busy),
    .xu_o      (xu),
    .yu_o      (yu),
    .ym_o      (ym),
    .xb_o      (xb),
    .yb_o      (yb),
    .s_ub_o    (s_ub),
    .s_um_o    (s_um),
    .s_mb_o    (s_mb)
  );

  tss_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .row_i   (s_axis_tdata[COORD_BITS-1:0]),
    .busy_i  (busy),
    .qstat_i (qstat),
    .yu_i    (yu),
    .ym_i    (ym),
    .yb_i    (yb),
    .push_o  (push),
    .entry_o (q_in)
  );

  tss_queue #(
    .WIDTH (QW),
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (q_in),
    .pop_i  (pop),
    .data_o (q_out),
    .stat_o (qstat)
  );

  tss_back #(
    .COORD_BITS      (COORD_BITS),
    .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .qstat_i   (qstat),
    .entry_i   (q_out),
    .pop_o     (pop),
    .xu_i      (xu),
    .xb_i      (xb),
    .s_ub_i    (s_ub),
    .s_um_i    (s_um),
    .s_mb_i    (s_mb),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .covered_o (covered),
    .start_o   (span_start),
    .end_o     (span_end)
  );

  assign m_axis_tdata = {{OPAD{1'b0}}, span_end, span_start, covered};

endmodule

// File: rtl/tss_checker.sv
// Port-level checks for the triangle scanline span unit, bound to the top.
// Depends on tss_pkg and triangle_scanline_span_unit.
module tss_checker
  import tss_pkg::*;
#(
  parameter int unsigned COORD_BITS = CoordBitsDef
) (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    cfg_valid_i,
  input logic                                    cfg_ready_o,
  input logic                                    s_axis_tready,
  input logic                                    m_axis_tvalid,
  input logic                                    m_axis_tready,
  input logic [((2*COORD_BITS+2+7)/8)*8-1:0]     m_axis_tdata
);

  logic                  cov;
  logic [COORD_BITS-1:0] st;
  logic [COORD_BITS:0]   en;
  assign cov = m_axis_tdata[0];
  assign st  = m_axis_tdata[COORD_BITS:1];
  assign en  = m_axis_tdata[2*COORD_BITS+1:COORD_BITS+1];

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // an uncovered row carries a zero span
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !cov |-> st == '0 && en == '0)
    else $error("uncovered row with nonzero span");

  // a covered span is never empty
  a_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && cov |-> en > {1'b0, st})
    else $error("covered span is empty");

  // a register write starts setup, which blocks new rows
  a_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_ready_o |=> !s_axis_tready)
    else $error("row taken during setup");

endmodule

bind triangle_scanline_span_unit tss_checker #(
  .COORD_BITS (COORD_BITS)
) u_tss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: test/triangle_scanline_span_unit_test.sv
// Testbench for triangle_scanline_span_unit: random rows against a span predictor.
// Depends on tss_pkg and the unit's RTL.

class span_scoreboard;
  // current vertex registers
  int unsigned vtx_x[3];
  int unsigned vtx_y[3];
  bit [25:0] expected_spans[$];
  int unsigned fail_count;

  function new();
    fail_count = 0;
    for (int i = 0; i < 3; i++) begin
      vtx_x[i] = 0;
      vtx_y[i] = 0;
    end
  endfunction

  function void set_reg(int unsigned idx, int unsigned value);
    if (idx < 6) begin
      if (idx % 2 == 0) vtx_x[idx / 2] = value & 12'hfff;
      else vtx_y[idx / 2] = value & 12'hfff;
    end
  endfunction

  function longint edge_slope(longint x1, longint y1, longint x2, longint y2);
    if (y2 == y1) return 0;
    return ((x2 - x1) * 65536) / (y2 - y1);
  endfunction

  // compute span for one row and queue it
  function void note_row(int unsigned row_in);
    int top, mid, bot, t;
    longint row, xu, yu, xm, ym, xb, yb, s_ub, s_um, s_mb, e1, e2, lo, hi, st, en;
    bit [25:0] res;
    top = 0; mid = 1; bot = 2;
    row = row_in & 12'hfff;
    res = '0;
    if (vtx_y[mid] < vtx_y[top]) begin t = top; top = mid; mid = t; end
    if (vtx_y[bot] < vtx_y[top]) begin t = top; top = bot; bot = t; end
    if (vtx_y[bot] < vtx_y[mid]) begin t = bot; bot = mid; mid = t; end
    xu = vtx_x[top]; yu = vtx_y[top];
    xm = vtx_x[mid]; ym = vtx_y[mid];
    xb = vtx_x[bot]; yb = vtx_y[bot];
    if (row >= yu && row <= yb) begin
      s_ub = edge_slope(xu, yu, xb, yb);
      s_um = edge_slope(xu, yu, xm, ym);
      s_mb = edge_slope(xm, ym, xb, yb);
      if (row < ym) begin
        e1 = xu * 65536 + s_um * (row - yu);
        e2 = xu * 65536 + s_ub * (row - yu);
      end else begin
        e1 = xb * 65536 + s_mb * (row - yb);
        e2 = xb * 65536 + s_ub * (row - yb);
      end
      lo = e1 < e2 ? e1 : e2;
      hi = e1 < e2 ? e2 : e1;
      st = lo < 0 ? 0 : lo / 65536;
      if (st > 4095) st = 4095;
      en = hi <= 0 ? 0 : (hi + 65535) / 65536;
      if (en > 4096) en = 4096;
      if (en > st) begin
        res[0] = 1'b1;
        res[12:1] = st[11:0];
        res[25:13] = en[12:0];
      end
    end
    expected_spans.push_back(res);
  endfunction

  function void check_span(bit [25:0] got);
    bit [25:0] want;
    if (expected_spans.size() == 0) begin
      $error("span with no expected result: %h", got);
      fail_count++;
      return;
    end
    want = expected_spans.pop_front();
    if (got[0] != want[0]) begin
      $error("covered: expected %0d actual %0d", want[0], got[0]);
      fail_count++;
    end
    if (got[12:1] != want[12:1]) begin
      $error("span_start: expected %0d actual %0d", want[12:1], got[12:1]);
      fail_count++;
    end
    if (got[25:13] != want[25:13]) begin
      $error("span_end: expected %0d actual %0d", want[25:13], got[25:13]);
      fail_count++;
    end
  endfunction
endclass

module triangle_scanline_span_unit_test;
  import tss_pkg::*;

  localparam int unsigned CycleLimit = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i = '0;
  logic [11:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [11:0] row
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [0] covered, [12:1] start, [25:13] end

  bit quiet_tail = 1'b0;  // no idling near the end
  int unsigned cycles = 0;
  span_scoreboard sb = new();

  triangle_scanline_span_unit dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // run guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL triangle_scanline_span_unit");
      $finish;
    end
  end

  // receiver: sample at rising edge, change ready at falling edge
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_span(m_axis_tdata[25:0]);
  end

  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        stall = $urandom_range(1, 7);
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input int unsigned value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[11:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // wait for every expected span, then let the pipe settle
  task automatic drain();
    while (sb.expected_spans.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic load_triangle(input int unsigned ax, ay, bx, by, cx, cy);
    drain();
    write_reg(RegAX, ax); write_reg(RegAY, ay);
    write_reg(RegBX, bx); write_reg(RegBY, by);
    write_reg(RegCX, cx); write_reg(RegCY, cy);
  endtask

  // one row transaction; valid stays high across back-to-back rows
  task automatic send_row(input int unsigned row);
    int unsigned gap;
    if (!quiet_tail && $urandom_range(0, 6) == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 7);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'h0, row[11:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_row(row);
    @(negedge clk_i);
  endtask

  function automatic int unsigned pick_coord();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 4095;
      2: return $urandom_range(0, 31);
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  initial begin
    int unsigned lo_y, hi_y;
    int unsigned ys[3];
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset triangle: all vertices at origin
    send_row(0); send_row(4095);
    // full-range triangle with flat top and extreme coordinates
    s_axis_tvalid <= 1'b0;
    load_triangle(0, 0, 4095, 0, 2048, 4095);
    foreach (ys[i]) ys[i] = 0;
    send_row(0); send_row(1); send_row(2047); send_row(4094); send_row(4095);
    // flat bottom, tied y order, row outside
    s_axis_tvalid <= 1'b0;
    load_triangle(100, 50, 10, 10, 200, 50);
    send_row(9); send_row(10); send_row(11); send_row(49); send_row(50); send_row(51);
    // degenerate line and middle-row split
    s_axis_tvalid <= 1'b0;
    load_triangle(5, 5, 5, 20, 5, 40);
    send_row(5); send_row(20); send_row(30);
    s_axis_tvalid <= 1'b0;
    load_triangle(4095, 4095, 0, 4000, 3000, 3000);
    send_row(3000); send_row(3999); send_row(4000); send_row(4001); send_row(4095);
    send_row(2730);

    // random triangles, rows mostly inside their y range
    for (int tri_n = 0; tri_n < 60; tri_n++) begin
      s_axis_tvalid <= 1'b0;
      if (tri_n % 3 == 0) begin
        lo_y = $urandom_range(0, 4095);
        load_triangle(pick_coord(), lo_y, pick_coord(), lo_y + $urandom_range(0, 40),
                      pick_coord(), lo_y + $urandom_range(0, 40));
      end else begin
        load_triangle(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                      pick_coord(), pick_coord());
      end
      foreach (ys[i]) ys[i] = sb.vtx_y[i];
      lo_y = ys[0]; hi_y = ys[0];
      foreach (ys[i]) begin
        if (ys[i] < lo_y) lo_y = ys[i];
        if (ys[i] > hi_y) hi_y = ys[i];
      end
      if (tri_n == 58) quiet_tail = 1'b1;
      for (int k = 0; k < 30; k++) begin
        if ($urandom_range(0, 9) == 0) send_row($urandom_range(0, 4095));
        else send_row($urandom_range(lo_y, hi_y));
      end
      // hold off until the pipe is empty once mid-run
      if (tri_n == 20) begin
        s_axis_tvalid <= 1'b0;
        drain();
      end
    end
    s_axis_tvalid <= 1'b0;
    drain();
    repeat (10) @(negedge clk_i);
    if (sb.fail_count == 0 && sb.expected_spans.size() == 0) begin
      $display("PASS triangle_scanline_span_unit");
    end else begin
      $display("FAIL triangle_scanline_span_unit");
    end
    $finish;
  end
endmodule
